FILE: rtl/ast_pkg.sv
package ast_pkg;

    // Default table depths; both must be powers of two.
    localparam int PTR_SLOTS_DEF  = 4096;
    localparam int SITE_SLOTS_DEF = 1024;

    localparam logic [47:0] KEY_EMPTY = 48'd0;
    localparam logic [47:0] KEY_TOMB  = 48'd1;
    localparam logic [47:0] MAX48     = {48{1'b1}};
    localparam logic [31:0] MAX32     = {32{1'b1}};
    localparam logic        OP_ALLOC  = 1'b0;
    localparam logic        OP_FREE   = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [47:0] address;
        logic [31:0] alloc_size;
        logic [47:0] call_site;
    } in_item_t;

    typedef struct packed {
        logic        ptr_recorded;
        logic        site_updated;
        logic [47:0] site_live_bytes;
        logic [47:0] site_alloc_bytes;
        logic [31:0] site_alloc_count;
        logic [31:0] site_free_count;
        logic [31:0] freed_size;
        logic [47:0] freed_site;
    } out_item_t;

    typedef struct packed {
        logic [47:0] key;
        logic [31:0] size;
        logic [47:0] site;
    } ptr_entry_t;

    typedef struct packed {
        logic [47:0] key;
        logic [47:0] live;
        logic [47:0] total;
        logic [31:0] allocs;
        logic [31:0] frees;
    } site_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P_RD,
        ST_P_CHK,
        ST_S_START,
        ST_S_RD,
        ST_S_CHK,
        ST_DONE
    } ast_state_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic p_read;
        logic p_next;
        logic p_write;
        logic s_start;
        logic s_read;
        logic s_next;
        logic s_write;
        logic out_load;
    } ast_cmd_t;

    typedef struct packed {
        logic ignored;
        logic is_free;
        logic p_hit;
        logic p_empty;
        logic p_last;
        logic p_tomb_avail;
        logic site_zero;
        logic s_hit;
        logic s_empty;
        logic s_last;
        logic clr_done;
        logic out_free;
    } ast_stat_t;

    // Probe start hash before reduction to the table depth.
    function automatic logic [47:0] hash_of(input logic [47:0] a);
        hash_of = (a >> 4) ^ (a >> 9);
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        sat_add48 = s[48] ? MAX48 : s[47:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        sat_inc32 = (a == MAX32) ? MAX32 : a + 32'd1;
    endfunction

endpackage

FILE: rtl/ast_ctrl.sv
module ast_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ast_pkg::ast_stat_t stat,
    output ast_pkg::ast_cmd_t  cmd
);
    import ast_pkg::*;

    ast_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_P_RD;
                end
            end
            ST_P_RD:
            begin
                if (stat.ignored)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.p_read = 1'b1;
                    state_next = ST_P_CHK;
                end
            end
            ST_P_CHK:
            begin
                if (stat.p_hit || stat.p_empty || stat.p_last)
                begin
                    if (stat.is_free)
                    begin
                        if (stat.p_hit)
                        begin
                            cmd.p_write = 1'b1;
                            state_next  = stat.site_zero ? ST_DONE : ST_S_START;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        cmd.p_write = stat.p_hit || stat.p_empty || stat.p_tomb_avail;
                        state_next  = stat.site_zero ? ST_DONE : ST_S_START;
                    end
                end
                else
                begin
                    cmd.p_next = 1'b1;
                    state_next = ST_P_RD;
                end
            end
            ST_S_START:
            begin
                cmd.s_start = 1'b1;
                state_next  = ST_S_RD;
            end
            ST_S_RD:
            begin
                cmd.s_read = 1'b1;
                state_next = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                if (stat.s_hit || (stat.s_empty && !stat.is_free))
                begin
                    cmd.s_write = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (stat.s_empty || stat.s_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.s_next = 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ast_dpath.sv
module ast_dpath #(
    parameter int PTR_SLOTS  = ast_pkg::PTR_SLOTS_DEF,
    parameter int SITE_SLOTS = ast_pkg::SITE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ast_pkg::in_item_t  in_item,
    input  logic               cfg_valid,
    input  logic [0:0]         cfg_data,
    input  ast_pkg::ast_cmd_t  cmd,
    output ast_pkg::ast_stat_t stat,
    output logic               out_valid,
    input  logic               out_stall,
    output ast_pkg::out_item_t out_item
);
    import ast_pkg::*;

    localparam int PW      = $clog2(PTR_SLOTS);
    localparam int SW      = $clog2(SITE_SLOTS);
    localparam int MAXS    = (PTR_SLOTS > SITE_SLOTS) ? PTR_SLOTS : SITE_SLOTS;
    localparam int CW      = $clog2(MAXS) + 1;
    localparam logic [CW-1:0] PTR_END  = CW'(PTR_SLOTS);
    localparam logic [CW-1:0] SITE_END = CW'(SITE_SLOTS);
    localparam logic [CW-1:0] CLR_LAST = CW'(MAXS - 1);

    ptr_entry_t  ptr_mem  [PTR_SLOTS];
    site_entry_t site_mem [SITE_SLOTS];

    logic        en_reg;
    in_item_t    item_reg;
    logic [PW-1:0] idx_reg, n_reg, tomb_reg;
    logic        tomb_vld_reg;
    logic [SW-1:0] sidx_reg, sn_reg;
    logic [CW-1:0] clr_reg;
    ptr_entry_t  ptr_rd_reg;
    site_entry_t site_rd_reg;
    out_item_t   res_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic [47:0] skey;
    logic [47:0] in_hash, site_hash;
    logic        ptr_we, site_we;
    logic [PW-1:0] ptr_waddr;
    logic [SW-1:0] site_waddr;
    ptr_entry_t  ptr_wdata;
    site_entry_t site_wdata, site_upd;

    // Enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            en_reg <= cfg_data[0];
        end
    end

    assign skey = (item_reg.operation == OP_FREE) ? res_reg.freed_site : item_reg.call_site;

    // Probe start points for both tables.
    assign in_hash   = hash_of(in_item.address);
    assign site_hash = hash_of(skey);

    // Status towards the controller.
    always_comb
    begin
        stat.ignored      = !en_reg || (item_reg.address == KEY_EMPTY)
                            || (item_reg.address == KEY_TOMB);
        stat.is_free      = (item_reg.operation == OP_FREE);
        stat.p_hit        = (ptr_rd_reg.key == item_reg.address);
        stat.p_empty      = (ptr_rd_reg.key == KEY_EMPTY);
        stat.p_last       = (n_reg == PW'(PTR_SLOTS - 1));
        stat.p_tomb_avail = tomb_vld_reg || (ptr_rd_reg.key == KEY_TOMB);
        stat.site_zero    = stat.is_free ? (ptr_rd_reg.site == 48'd0)
                                         : (item_reg.call_site == 48'd0);
        stat.s_hit        = (site_rd_reg.key == skey);
        stat.s_empty      = (site_rd_reg.key == KEY_EMPTY);
        stat.s_last       = (sn_reg == SW'(SITE_SLOTS - 1));
        stat.clr_done     = (clr_reg == CLR_LAST);
        stat.out_free     = !out_valid_reg || !out_stall;
    end

    // Updated site entry.
    always_comb
    begin
        site_upd     = site_rd_reg;
        site_upd.key = skey;
        if (item_reg.operation == OP_FREE)
        begin
            site_upd.live  = (site_rd_reg.live >= {16'd0, res_reg.freed_size})
                             ? site_rd_reg.live - {16'd0, res_reg.freed_size} : 48'd0;
            site_upd.frees = sat_inc32(site_rd_reg.frees);
        end
        else
        begin
            site_upd.live   = sat_add48(site_rd_reg.live, item_reg.alloc_size);
            site_upd.total  = sat_add48(site_rd_reg.total, item_reg.alloc_size);
            site_upd.allocs = sat_inc32(site_rd_reg.allocs);
        end
    end

    // Write port selection for both tables.
    always_comb
    begin
        ptr_we     = cmd.p_write || (cmd.clear && (clr_reg < PTR_END));
        site_we    = cmd.s_write || (cmd.clear && (clr_reg < SITE_END));
        ptr_waddr  = clr_reg[PW-1:0];
        site_waddr = clr_reg[SW-1:0];
        ptr_wdata  = '0;
        site_wdata = '0;
        if (cmd.p_write)
        begin
            ptr_waddr = (!stat.p_hit && tomb_vld_reg) ? tomb_reg : idx_reg;
            if (item_reg.operation == OP_FREE)
            begin
                ptr_wdata.key = KEY_TOMB;
            end
            else
            begin
                ptr_wdata.key  = item_reg.address;
                ptr_wdata.size = item_reg.alloc_size;
                ptr_wdata.site = item_reg.call_site;
            end
        end
        if (cmd.s_write)
        begin
            site_waddr = sidx_reg;
            site_wdata = site_upd;
        end
    end

    // Pointer table.
    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        if (cmd.p_read)
        begin
            ptr_rd_reg <= ptr_mem[idx_reg];
        end
    end

    // Site table.
    always_ff @(posedge clk)
    begin
        if (site_we)
        begin
            site_mem[site_waddr] <= site_wdata;
        end
        if (cmd.s_read)
        begin
            site_rd_reg <= site_mem[sidx_reg];
        end
    end

    // Clearing sweep counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear && !stat.clr_done)
        begin
            clr_reg <= clr_reg + CW'(1);
        end
    end

    // Item, probe and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            item_reg     <= in_item;
            idx_reg      <= in_hash[PW-1:0];
            n_reg        <= '0;
            tomb_vld_reg <= 1'b0;
            res_reg      <= '0;
        end
        if (cmd.p_next)
        begin
            if (!tomb_vld_reg && (ptr_rd_reg.key == KEY_TOMB))
            begin
                tomb_reg     <= idx_reg;
                tomb_vld_reg <= 1'b1;
            end
            idx_reg <= idx_reg + PW'(1);
            n_reg   <= n_reg + PW'(1);
        end
        if (cmd.p_write)
        begin
            res_reg.ptr_recorded <= 1'b1;
            if (item_reg.operation == OP_FREE)
            begin
                res_reg.freed_size <= ptr_rd_reg.size;
                res_reg.freed_site <= ptr_rd_reg.site;
            end
        end
        if (cmd.s_start)
        begin
            sidx_reg <= site_hash[SW-1:0];
            sn_reg   <= '0;
        end
        if (cmd.s_next)
        begin
            sidx_reg <= sidx_reg + SW'(1);
            sn_reg   <= sn_reg + SW'(1);
        end
        if (cmd.s_write)
        begin
            res_reg.site_updated     <= 1'b1;
            res_reg.site_live_bytes  <= site_upd.live;
            res_reg.site_alloc_bytes <= site_upd.total;
            res_reg.site_alloc_count <= site_upd.allocs;
            res_reg.site_free_count  <= site_upd.frees;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    // The sweep never shares the write port with an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.p_write || cmd.s_write |-> !cmd.clear)
        else $error("table write during clearing sweep");

    // A pending result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || !out_stall)
        else $error("result overwritten while stalled");

    // A site entry is only ever written with a real call site.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.s_write |-> skey != KEY_EMPTY)
        else $error("site entry written with a null key");
`endif

endmodule

FILE: rtl/allocation_site_tracker_top.sv
// Channel   Direction  Handshake         Payload
// in        input      in_valid/in_stall in_item (operation, address, size, site)
// out       output     out_valid/out_stall out_item (eight result fields)
// cfg       input      cfg_valid/cfg_ready cfg_data (enable)
//
// An item passes entry, a probe of the pointer table slot by slot and, when a
// site is touched, a probe of the site table, then hand-over; a disabled or null
// item skips both probes. Each probe is one registered table read.
// After reset the block sweeps both tables and holds in_stall high until done.
// Configuration writes are always taken.
// A stalled result waits in the output register while the next item is taken.
module allocation_site_tracker_top #(
    parameter int PTR_SLOTS  = ast_pkg::PTR_SLOTS_DEF,
    parameter int SITE_SLOTS = ast_pkg::SITE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ast_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output ast_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_data
);
    import ast_pkg::*;

    ast_cmd_t  cmd;
    ast_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer.
    ast_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Tables and arithmetic.
    ast_dpath #(
        .PTR_SLOTS  (PTR_SLOTS),
        .SITE_SLOTS (SITE_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
